// ===== design/mpiq_pkg.sv =====
// Shared types and constants for the MPEG-2 inverse quantizer.
// Used by mpiq_front, mpiq_fifo, mpiq_back and the top level.
`default_nettype none

package mpiq_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LUMA_DC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_DC = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DC_SCALE_RST = 4'd8;

  // Field widths
  localparam int unsigned COEF_W  = 12;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned QS_W    = 7;
  localparam int unsigned LEVEL_W = 16;

  localparam logic [POS_W-1:0] POS_DC   = 6'd0;
  localparam logic [POS_W-1:0] POS_LAST = 6'd63;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_DC    = 2'd0,
    KIND_INTRA = 2'd1,
    KIND_INTER = 2'd2
  } mpiq_kind_e;

  // Classified item: the back end computes opa * opb (low 16 bits) and
  // then shifts and signs according to kind.
  typedef struct packed {
    mpiq_kind_e         kind;
    logic               zero;
    logic               neg;
    logic [LEVEL_W-1:0] opa;
    logic [LEVEL_W-1:0] opb;
    logic               block_end;
  } mpiq_op_t;

endpackage

`default_nettype wire

// ===== design/mpiq_front.sv =====
// Front end: accepts coefficient items, classifies them and forms the
// multiplier operands (q = quant_scale * weight). Depends on mpiq_pkg.
`default_nettype none

module mpiq_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [mpiq_pkg::COEF_W-1:0]  coefficient_i,
  input  wire logic [mpiq_pkg::POS_W-1:0]          position_i,
  input  wire logic [mpiq_pkg::WEIGHT_W-1:0]       weight_i,
  input  wire logic [mpiq_pkg::QS_W-1:0]           quant_scale_i,
  input  wire logic                                is_intra_i,
  input  wire logic                                is_luma_i,
  input  wire logic [mpiq_pkg::CFG_DATA_W-1:0]     luma_dc_scale_i,
  input  wire logic [mpiq_pkg::CFG_DATA_W-1:0]     chroma_dc_scale_i,
  output logic                                     op_valid_o,
  input  wire logic                                op_ready_i,
  output mpiq_pkg::mpiq_op_t                       op_o
);
  import mpiq_pkg::*;

  logic                        valid_q;
  mpiq_op_t                    op_q, op_d;
  logic [COEF_W-1:0]           coef_u;
  logic                        neg;
  logic [COEF_W-1:0]           mag;
  logic [QS_W+WEIGHT_W-1:0]    q;
  logic [CFG_DATA_W-1:0]       dc_scale;
  logic                        accept;

  assign coef_u   = coefficient_i;
  assign neg      = coef_u[COEF_W-1];
  assign mag      = neg ? (~coef_u + 12'd1) : coef_u;
  assign q        = (QS_W+WEIGHT_W)'(quant_scale_i) * (QS_W+WEIGHT_W)'(weight_i);
  assign dc_scale = is_luma_i ? luma_dc_scale_i : chroma_dc_scale_i;

  always_comb begin
    op_d.zero      = (coef_u == '0);
    op_d.neg       = neg;
    op_d.block_end = (position_i == POS_LAST);
    if (is_intra_i && position_i == POS_DC) begin
      op_d.kind = KIND_DC;
      op_d.opa  = {{(LEVEL_W-COEF_W){coef_u[COEF_W-1]}}, coef_u};
      op_d.opb  = {{(LEVEL_W-CFG_DATA_W){1'b0}}, dc_scale};
    end else if (is_intra_i) begin
      op_d.kind = KIND_INTRA;
      op_d.opa  = {{(LEVEL_W-COEF_W){1'b0}}, mag};
      op_d.opb  = {1'b0, q};
    end else begin
      // (2|c| + 1) * q
      op_d.kind = KIND_INTER;
      op_d.opa  = {{(LEVEL_W-COEF_W-1){1'b0}}, mag, 1'b1};
      op_d.opb  = {1'b0, q};
    end
  end

  assign in_ready_o = !valid_q || op_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op_valid_o = valid_q;
  assign op_o       = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (op_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/mpiq_fifo.sv =====
// Short queue of classified items between front and back end.
// Depends on mpiq_pkg for the item type.
`default_nettype none

module mpiq_fifo #(
  parameter int unsigned Depth = mpiq_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_valid_i,
  output logic                     push_ready_o,
  input  wire mpiq_pkg::mpiq_op_t  push_data_i,
  output logic                     pop_valid_o,
  input  wire logic                pop_ready_i,
  output mpiq_pkg::mpiq_op_t       pop_data_o
);
  import mpiq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mpiq_op_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/mpiq_back.sv =====
// Back end: one 16x16 multiply, shift, sign restore and mismatch control,
// into the output register. Depends on mpiq_pkg.
`default_nettype none

module mpiq_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                op_valid_i,
  output logic                                     op_ready_o,
  input  wire mpiq_pkg::mpiq_op_t                  op_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [mpiq_pkg::LEVEL_W-1:0]      level_o,
  output logic                                     block_end_o
);
  import mpiq_pkg::*;

  logic                  out_valid_q;
  logic [LEVEL_W-1:0]    level_q, level_d;
  logic                  block_end_q;
  logic                  parity_q, parity_d;
  logic                  pop;
  logic [LEVEL_W-1:0]    product;
  logic [LEVEL_W-1:0]    mag16;
  logic [LEVEL_W-1:0]    signed_mag;
  logic [LEVEL_W-1:0]    lvl;
  logic                  par_x;

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign pop        = op_valid_i && op_ready_o;

  // only the low 16 bits of the product are ever used
  assign product = op_i.opa * op_i.opb;

  // intra: arithmetic shift by 3, inter: logical shift by 4
  assign mag16      = (op_i.kind == KIND_INTRA) ? LEVEL_W'($signed(product) >>> 3)
                                                : (product >> 4);
  assign signed_mag = op_i.neg ? (~mag16 + 16'd1) : mag16;

  always_comb begin
    case (op_i.kind) inside
      KIND_DC:    lvl = product;
      KIND_INTRA,
      KIND_INTER: lvl = op_i.zero ? '0 : signed_mag;
      default:    lvl = '0;
    endcase
  end

  // mismatch control: parity starts at one, toggles LSB of the last
  // coefficient when the inter level sum is even
  assign par_x = parity_q ^ lvl[0];

  always_comb begin
    level_d  = lvl;
    parity_d = parity_q;
    if (op_i.kind == KIND_INTER) begin
      parity_d = par_x;
      if (op_i.block_end && par_x) begin
        level_d = {lvl[LEVEL_W-1:1], ~lvl[0]};
      end
    end
    if (op_i.block_end) begin
      parity_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      parity_q    <= 1'b1;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
        parity_q    <= parity_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      level_q     <= level_d;
      block_end_q <= op_i.block_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign block_end_o = block_end_q;

  a_parity_reset_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && op_i.block_end |=> parity_q)
    else $error("parity not reset after block end");

  a_parity_tracks_inter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && op_i.kind == KIND_INTER && !op_i.block_end
    |=> parity_q == ($past(parity_q) ^ level_q[0]))
    else $error("parity does not follow inter level LSB");

  a_intra_keeps_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && op_i.kind != KIND_INTER && !op_i.block_end |=> $stable(parity_q))
    else $error("intra item changed parity");

  a_intra_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && op_i.kind == KIND_INTRA && op_i.zero |=> level_q == '0)
    else $error("zero intra AC coefficient gave nonzero level");

endmodule

`default_nettype wire

// ===== design/mpeg2_inverse_quantizer_unit.sv =====
// Top level of the MPEG-2 inverse quantizer with mismatch control.
// Instantiates mpiq_front, mpiq_fifo and mpiq_back; depends on mpiq_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o): one quantized coefficient per
//   item, raster order, with its weight, quant_scale and intra/luma flags.
//   Output channel (out_valid_o/out_ready_i): one dequantized level per
//   item, in order; block_end_o marks the result for position 63.
//   Config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 = luma DC scale, 1 = chroma DC scale) in the same cycle, no wait.
//   Write only while no item is in flight.
// Timing:
//   out_valid_o rises once an item has passed the front register, the queue
//   and the back output register. Throughput is one item per cycle while
//   out_ready_i stays high; the back end holds one 16x16 multiplier, the
//   front one 7x8 multiplier.
// Reset: DC scales return to 8, mismatch parity to one, all pipeline
//   stages and the queue empty.
// Stall: when out_ready_i is low the output register holds, the back end
//   stops popping, the queue fills, then the front and finally in_ready_o
//   drop. Up to four items are buffered inside.
`default_nettype none

module mpeg2_inverse_quantizer_unit #(
  parameter int unsigned QueueDepth = mpiq_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [mpiq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mpiq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input items
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [mpiq_pkg::COEF_W-1:0]  coefficient_i,
  input  wire logic [mpiq_pkg::POS_W-1:0]          position_i,
  input  wire logic [mpiq_pkg::WEIGHT_W-1:0]       weight_i,
  input  wire logic [mpiq_pkg::QS_W-1:0]           quant_scale_i,
  input  wire logic                                is_intra_i,
  input  wire logic                                is_luma_i,
  // result items
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [mpiq_pkg::LEVEL_W-1:0]      level_o,
  output logic                                     block_end_o
);
  import mpiq_pkg::*;

  // DC scale registers
  logic [CFG_DATA_W-1:0] luma_dc_scale_q;
  logic [CFG_DATA_W-1:0] chroma_dc_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_dc_scale_q   <= DC_SCALE_RST;
      chroma_dc_scale_q <= DC_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LUMA_DC:   luma_dc_scale_q   <= cfg_data_i;
        REG_CHROMA_DC: chroma_dc_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front -> queue
  logic     fr_valid, fr_ready;
  mpiq_op_t fr_op;
  // queue -> back
  logic     bk_valid, bk_ready;
  mpiq_op_t bk_op;

  mpiq_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .coefficient_i     (coefficient_i),
    .position_i        (position_i),
    .weight_i          (weight_i),
    .quant_scale_i     (quant_scale_i),
    .is_intra_i        (is_intra_i),
    .is_luma_i         (is_luma_i),
    .luma_dc_scale_i   (luma_dc_scale_q),
    .chroma_dc_scale_i (chroma_dc_scale_q),
    .op_valid_o        (fr_valid),
    .op_ready_i        (fr_ready),
    .op_o              (fr_op)
  );

  mpiq_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_op),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_op)
  );

  mpiq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (bk_valid),
    .op_ready_o  (bk_ready),
    .op_i        (bk_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .level_o     (level_o),
    .block_end_o (block_end_o)
  );

endmodule

`default_nettype wire

// ===== tb/mpeg2_inverse_quantizer_unit_test.sv =====
// Self-checking testbench for mpeg2_inverse_quantizer_unit: dequantization, DC scaling
// and mismatch control are predicted in-bench and compared result by result.
// Depends on mpiq_pkg and the mpeg2_inverse_quantizer_unit RTL only.
`default_nettype none

module mpeg2_inverse_quantizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpiq_pkg::*;

  localparam int unsigned HOLDOFF_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES   = 6;   // leave some margin

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic               block_end;
  } dq_result_t;

  // DUT inputs, all known from time zero
  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i    = REG_LUMA_DC;
  logic [CFG_DATA_W-1:0]      cfg_data_i     = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic signed [COEF_W-1:0]   coefficient_i  = '0;
  logic [POS_W-1:0]           position_i     = '0;
  logic [WEIGHT_W-1:0]        weight_i       = '0;
  logic [QS_W-1:0]            quant_scale_i  = '0;
  logic                       is_intra_i     = 1'b0;
  logic                       is_luma_i      = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic signed [LEVEL_W-1:0]  level_o;
  logic                       block_end_o;

  // Predictor state: DC scales and the running mismatch parity
  logic [CFG_DATA_W-1:0] luma_dc_mult   = DC_SCALE_RST;
  logic [CFG_DATA_W-1:0] chroma_dc_mult = DC_SCALE_RST;
  logic                  mismatch_parity = 1'b1;

  dq_result_t pending_levels[$];

  // Pacing knobs, percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Long output hold-off: the test bumps the request count, the receiver counts it out
  int unsigned holdoff_reqs = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;

  int unsigned error_count    = 0;
  int unsigned coefs_accepted = 0;
  int unsigned levels_checked = 0;
  int unsigned blocks_closed  = 0;

  mpeg2_inverse_quantizer_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .coefficient_i(coefficient_i),
    .position_i   (position_i),
    .weight_i     (weight_i),
    .quant_scale_i(quant_scale_i),
    .is_intra_i   (is_intra_i),
    .is_luma_i    (is_luma_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .level_o      (level_o),
    .block_end_o  (block_end_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Dequantize one coefficient and advance the mismatch parity.
  // Intra: (|c|*q)>>>3; inter: ((2|c|+1)*q)>>4; 16-bit wrap throughout.
  function automatic logic [LEVEL_W-1:0] dequantize(
    input logic [COEF_W-1:0]   raw,
    input logic [POS_W-1:0]    pos,
    input logic [WEIGHT_W-1:0] wt,
    input logic [QS_W-1:0]     qs,
    input logic                intra,
    input logic                luma
  );
    logic               neg;
    logic [COEF_W-1:0]  mag;
    logic [COEF_W:0]    mag2;
    logic [LEVEL_W-1:0] q;
    logic [LEVEL_W-1:0] prod;
    logic [LEVEL_W-1:0] shifted;
    logic [LEVEL_W-1:0] ext;
    logic [LEVEL_W-1:0] lvl;
    neg  = raw[COEF_W-1];
    mag  = neg ? (COEF_W'(0) - raw) : raw;   // -2048 gives 12'h800, read unsigned
    mag2 = {mag, 1'b0};
    q    = LEVEL_W'(qs) * LEVEL_W'(wt);
    if (intra) begin
      if (pos == POS_DC) begin
        // DC uses the register value as-is, even 0 or above 8
        ext = {{(LEVEL_W-COEF_W){raw[COEF_W-1]}}, raw};
        lvl = ext * LEVEL_W'(luma ? luma_dc_mult : chroma_dc_mult);
      end else if (raw == '0) begin
        lvl = '0;
      end else begin
        prod    = LEVEL_W'(mag) * q;
        shifted = {{3{prod[LEVEL_W-1]}}, prod[LEVEL_W-1:3]};
        lvl     = neg ? (LEVEL_W'(0) - shifted) : shifted;
      end
    end else begin
      if (raw == '0) begin
        lvl = '0;
      end else begin
        prod    = LEVEL_W'(mag2) * q + q;
        shifted = prod >> 4;
        lvl     = neg ? (LEVEL_W'(0) - shifted) : shifted;
      end
      mismatch_parity ^= lvl[0];
      // even sum at block end: flip the LSB of the last coefficient
      if (pos == POS_LAST && mismatch_parity) lvl[0] = ~lvl[0];
    end
    if (pos == POS_LAST) mismatch_parity = 1'b1;
    return lvl;
  endfunction

  // Offer one coefficient, hold it until accepted, then predict its level
  task automatic send_coef(
    input logic [COEF_W-1:0]   raw,
    input logic [POS_W-1:0]    pos,
    input logic [WEIGHT_W-1:0] wt,
    input logic [QS_W-1:0]     qs,
    input logic                intra,
    input logic                luma
  );
    dq_result_t res;
    // each cycle idles with the set probability
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    coefficient_i <= raw;
    position_i    <= pos;
    weight_i      <= wt;
    quant_scale_i <= qs;
    is_intra_i    <= intra;
    is_luma_i     <= luma;
    do @(posedge clk_i); while (!in_ready_o);
    res.level     = dequantize(raw, pos, wt, qs, intra, luma);
    res.block_end = (pos == POS_LAST);
    pending_levels.push_back(res);
    coefs_accepted++;
  endtask

  // Stop offering and let every expected level come out
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both DC scales back to back; only called with the pipe empty
  task automatic set_dc_scales(input logic [CFG_DATA_W-1:0] luma_s,
                               input logic [CFG_DATA_W-1:0] chroma_s);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_LUMA_DC;
    cfg_data_i  <= luma_s;
    @(posedge clk_i);
    luma_dc_mult = luma_s;
    cfg_index_i <= REG_CHROMA_DC;
    cfg_data_i  <= chroma_s;
    @(posedge clk_i);
    chroma_dc_mult = chroma_s;
    cfg_we_i <= 1'b0;
  endtask

  // Mostly zeros and small levels, like real run-length output, with some full range
  function automatic logic [COEF_W-1:0] rand_coef();
    int unsigned pick;
    logic [COEF_W-1:0] c;
    pick = $urandom_range(9);
    if (pick < 5)       c = '0;
    else if (pick < 8)  c = COEF_W'($urandom_range(1, 8));
    else if (pick < 9)  c = COEF_W'($urandom_range(1, 255));
    else                c = COEF_W'($urandom);
    if (pick >= 5 && pick < 9 && $urandom_range(1)) c = COEF_W'(0) - c;
    return c;
  endfunction

  // One full, ordered 8x8 block with a fixed type and scale
  task automatic send_block(input logic intra, input logic luma);
    logic [QS_W-1:0] qs;
    qs = QS_W'($urandom_range(0, 127));
    for (int p = 0; p < 64; p++) begin
      send_coef(rand_coef(), POS_W'(p), WEIGHT_W'($urandom_range(0, 255)), qs, intra, luma);
    end
  endtask

  // Receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (holdoff_reqs != holdoff_seen) begin
      holdoff_seen = holdoff_reqs;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every accepted level against the oldest prediction
  always @(posedge clk_i) begin
    dq_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected level %0d, nothing pending", level_o);
        error_count++;
      end else begin
        want = pending_levels.pop_front();
        if (level_o !== want.level) begin
          $error("level: expected %0d, actual %0d", $signed(want.level), level_o);
          error_count++;
        end
        if (block_end_o !== want.block_end) begin
          $error("block_end: expected %0b, actual %0b", want.block_end, block_end_o);
          error_count++;
        end
        levels_checked++;
        if (want.block_end) blocks_closed++;
      end
    end
  end

  // Field extremes, zero weight/scale, DC with reset scales, parity corner cases
  task automatic test_directed_edges();
    // intra DC luma/chroma at the reset multiplier of 8
    send_coef(12'h800, POS_DC, 8'd16, 7'd1, 1'b1, 1'b1);
    send_coef(12'h7FF, POS_DC, 8'd16, 7'd1, 1'b1, 1'b0);
    send_coef(12'h000, POS_DC, 8'd255, 7'd127, 1'b1, 1'b1);
    // intra AC: largest products wrap and go through the arithmetic shift
    send_coef(12'h7FF, 6'd1, 8'd255, 7'd127, 1'b1, 1'b1);
    send_coef(12'h800, 6'd2, 8'd255, 7'd112, 1'b1, 1'b0);
    send_coef(12'h000, 6'd3, 8'd255, 7'd127, 1'b1, 1'b1);
    send_coef(12'h001, 6'd4, 8'd0, 7'd5, 1'b1, 1'b1);     // weight zero
    send_coef(12'hFFF, 6'd5, 8'd8, 7'd0, 1'b1, 1'b0);     // scale zero
    send_coef(12'd100, 6'd6, 8'd255, 7'd112, 1'b1, 1'b1);
    send_coef(12'hFFB, POS_LAST, 8'd16, 7'd3, 1'b1, 1'b1); // intra block end
    // inter: extremes of magnitude, weight and scale
    send_coef(12'h001, POS_DC, 8'd16, 7'd2, 1'b0, 1'b1);
    send_coef(12'hFFF, 6'd1, 8'd255, 7'd127, 1'b0, 1'b0);
    send_coef(12'h7FF, 6'd2, 8'd255, 7'd127, 1'b0, 1'b1);
    send_coef(12'h800, 6'd3, 8'd1, 7'd1, 1'b0, 1'b0);
    send_coef(12'h000, 6'd4, 8'd200, 7'd90, 1'b0, 1'b1);
    send_coef(12'h003, 6'd5, 8'd0, 7'd9, 1'b0, 1'b1);     // weight zero
    send_coef(12'h000, POS_LAST, 8'd16, 7'd1, 1'b0, 1'b1);
    // lone block end, even sum: zero becomes one
    send_coef(12'h000, POS_LAST, 8'd16, 7'd1, 1'b0, 1'b0);
    // lone block end, odd sum: level stays 3
    send_coef(12'h001, POS_LAST, 8'd16, 7'd1, 1'b0, 1'b1);
    // repeated position, then a negative block end
    send_coef(12'h005, 6'd7, 8'd32, 7'd4, 1'b0, 1'b1);
    send_coef(12'h005, 6'd7, 8'd32, 7'd4, 1'b0, 1'b1);
    send_coef(12'hFF9, POS_LAST, 8'd24, 7'd6, 1'b0, 1'b0);
    drain_pipeline();
  endtask

  // One pacing/config phase: ordered blocks, then broken sequences and raw noise
  task automatic test_dc_scale_phase(input logic [CFG_DATA_W-1:0] luma_s,
                                     input logic [CFG_DATA_W-1:0] chroma_s,
                                     input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned n;
    drain_pipeline();
    set_dc_scales(luma_s, chroma_s);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    send_block(1'b1, 1'($urandom_range(1)));
    send_block(1'b0, 1'($urandom_range(1)));
    // broken block: jumbled positions, intra and inter mixed, maybe closed
    n = $urandom_range(5, 40);
    for (int k = 0; k < n; k++) begin
      send_coef(rand_coef(),
                ($urandom_range(7) == 0) ? POS_LAST : POS_W'($urandom_range(0, 62)),
                WEIGHT_W'($urandom_range(0, 255)), QS_W'($urandom_range(0, 127)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    // noise: every field fully random
    for (int k = 0; k < 12; k++) begin
      send_coef(COEF_W'($urandom), POS_W'($urandom), WEIGHT_W'($urandom),
                QS_W'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  // Receiver blocks for a long stretch while the sender keeps pushing a block
  task automatic test_output_holdoff();
    drain_pipeline();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_reqs++;
    send_block(1'b0, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_dc_scale_phase(4'd1,  4'd8,  0,  0);    // no idling
    test_dc_scale_phase(4'd15, 4'd0,  66, 0);    // sender mostly idle
    test_dc_scale_phase(4'd0,  4'd15, 0,  66);   // receiver mostly stalled
    test_dc_scale_phase(CFG_DATA_W'($urandom_range(1, 8)),
                        CFG_DATA_W'($urandom_range(1, 8)), 8, 8);
    test_output_holdoff();
    drain_pipeline();

    $display("Sent %0d coefficients, checked %0d levels over %0d block ends;",
             coefs_accepted, levels_checked, blocks_closed);
    $display("DC scales 0..15, idle/stall pacing and a long output hold-off exercised.");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== mpeg2_inverse_quantizer_unit.f =====
design/mpiq_pkg.sv
design/mpiq_front.sv
design/mpiq_fifo.sv
design/mpiq_back.sv
design/mpeg2_inverse_quantizer_unit.sv
tb/mpeg2_inverse_quantizer_unit_test.sv
